// ===== rtl/core/unique_background_color_finder_macros.svh =====
// assertion macros shared by the finder rtl
`ifndef UNIQUE_BACKGROUND_COLOR_FINDER_MACROS_SVH
`define UNIQUE_BACKGROUND_COLOR_FINDER_MACROS_SVH

// same-cycle implication, quiet during reset
`define UBCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define UBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ubcf_pkg.sv =====
package ubcf_pkg;

    localparam int MAX_COLORS = 16;
    localparam int IDX_W      = $clog2(MAX_COLORS);
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int KEY_W      = 25;
    localparam int RGB_W      = 24;
    localparam int POS_W      = 8;

    localparam logic [7:0] VGA_BG_MASK      = 8'h70;
    localparam logic [7:0] COLUMNS_AT_RESET = 8'd80;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
        logic             cursor_ok;
    } t_cell;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/core/ubcf_front.sv =====
module ubcf_front import ubcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_screen_columns,
    input  logic             i_accept,
    input  logic             i_uses_rgb,
    input  logic [RGB_W-1:0] i_rgb_background,
    input  logic [7:0]       i_vga_attributes,
    input  logic [7:0]       i_hw_cursor_col,
    input  logic             i_last_cell,
    output t_cell            o_cell
);

    logic [7:0]       r_columns;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] edge_col;

    assign o_cfg_ready = 1'b1;
    // zero columns wraps to an edge of 255
    assign edge_col    = r_columns - 8'd1;

    always_comb begin
        o_cell.key       = i_uses_rgb ? {1'b1, i_rgb_background}
                                      : {{(KEY_W-8){1'b0}}, i_vga_attributes & VGA_BG_MASK};
        o_cell.col       = r_col;
        o_cell.row       = r_row;
        o_cell.last      = i_last_cell;
        o_cell.cursor_ok = (i_hw_cursor_col == 8'd0) || (i_hw_cursor_col == edge_col);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (i_last_cell) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == edge_col) begin
                n_col = '0;
                n_row = r_row + 8'd1;
            end else begin
                n_col = r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_AT_RESET;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_columns <= i_cfg_screen_columns;
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/core/ubcf_queue.sv =====
module ubcf_queue import ubcf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cell     i_cell,
    input  logic      i_pop,
    output t_cell     o_cell,
    output t_q_status o_status
);

    t_cell             r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_level;

    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == QCNT_W'(Q_DEPTH));
    assign o_cell         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + QCNT_W'(1);
                2'b01:   r_level <= r_level - QCNT_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ===== rtl/core/ubcf_back.sv =====
module ubcf_back import ubcf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell      i_cell,
    input  t_q_status  i_q_status,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic       o_found,
    output logic [7:0] o_cursor_col,
    output logic [7:0] o_cursor_row
);

    logic [KEY_W-1:0] r_single_key [MAX_COLORS];
    logic [POS_W-1:0] r_single_col [MAX_COLORS];
    logic [POS_W-1:0] r_single_row [MAX_COLORS];
    logic [KEY_W-1:0] r_repeat_key [MAX_COLORS];
    logic [CNT_W-1:0] r_single_cnt, n_single_cnt;
    logic [CNT_W-1:0] r_repeat_cnt, n_repeat_cnt;

    logic [KEY_W-1:0] n_single_key [MAX_COLORS];
    logic [POS_W-1:0] n_single_col [MAX_COLORS];
    logic [POS_W-1:0] n_single_row [MAX_COLORS];
    logic [KEY_W-1:0] n_repeat_key [MAX_COLORS];

    logic [MAX_COLORS-1:0] rep_match;
    logic [MAX_COLORS-1:0] single_match;
    logic [MAX_COLORS-1:0] at_or_after;
    logic                  rep_hit;
    logic                  single_hit;
    logic                  take;

    logic       r_out_valid;
    logic       r_found, n_found;
    logic [7:0] r_col,   n_col;
    logic [7:0] r_row,   n_row;

    // a last cell waits until the result slot is free
    assign take    = !i_q_status.empty && (!i_cell.last || !r_out_valid || i_pop);
    assign o_q_pop = take;

    always_comb begin
        for (int i = 0; i < MAX_COLORS; i++) begin
            rep_match[i]    = (CNT_W'(i) < r_repeat_cnt) && (r_repeat_key[i] == i_cell.key);
            single_match[i] = (CNT_W'(i) < r_single_cnt) && (r_single_key[i] == i_cell.key);
        end
        rep_hit    = |rep_match;
        single_hit = |single_match;
        at_or_after[0] = single_match[0];
        for (int i = 1; i < MAX_COLORS; i++) begin
            at_or_after[i] = at_or_after[i-1] | single_match[i];
        end
    end

    always_comb begin
        n_single_key = r_single_key;
        n_single_col = r_single_col;
        n_single_row = r_single_row;
        n_repeat_key = r_repeat_key;
        n_single_cnt = r_single_cnt;
        n_repeat_cnt = r_repeat_cnt;
        if (rep_hit) begin
            // colour already known to repeat
        end else if (single_hit) begin
            if (r_repeat_cnt < CNT_W'(MAX_COLORS)) begin
                n_repeat_key[r_repeat_cnt[IDX_W-1:0]] = i_cell.key;
                n_repeat_cnt = r_repeat_cnt + CNT_W'(1);
            end
            // close the gap left by the matched entry
            for (int k = 0; k < MAX_COLORS - 1; k++) begin
                if (at_or_after[k]) begin
                    n_single_key[k] = r_single_key[k+1];
                    n_single_col[k] = r_single_col[k+1];
                    n_single_row[k] = r_single_row[k+1];
                end
            end
            n_single_cnt = r_single_cnt - CNT_W'(1);
        end else if (r_single_cnt < CNT_W'(MAX_COLORS)) begin
            n_single_key[r_single_cnt[IDX_W-1:0]] = i_cell.key;
            n_single_col[r_single_cnt[IDX_W-1:0]] = i_cell.col;
            n_single_row[r_single_cnt[IDX_W-1:0]] = i_cell.row;
            n_single_cnt = r_single_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        n_found = i_cell.cursor_ok && (n_single_cnt == CNT_W'(1));
        n_col   = n_found ? n_single_col[0] : 8'd0;
        n_row   = n_found ? n_single_row[0] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_single_key <= n_single_key;
            r_single_col <= n_single_col;
            r_single_row <= n_single_row;
            r_repeat_key <= n_repeat_key;
        end
        if (take && i_cell.last) begin
            r_found <= n_found;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_cnt <= '0;
            r_repeat_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_single_cnt <= i_cell.last ? '0 : n_single_cnt;
                r_repeat_cnt <= i_cell.last ? '0 : n_repeat_cnt;
            end
            if (take && i_cell.last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_found      = r_found;
    assign o_cursor_col = r_col;
    assign o_cursor_row = r_row;

endmodule

// ===== rtl/core/unique_background_color_finder.sv =====
// unique background colour finder: screen cells arrive in raster order, one
// beat per cell, through a queue-like input (push/full). each cell's colour
// is reduced to a 25-bit key (rgb flag plus 24-bit rgb, or vga attribute bits
// 4 to 6), and the block tracks up to 16 colours seen once, with their
// positions, and up to 16 colours seen more than once. the beat flagged
// last_cell closes the frame and produces exactly one result beat on the
// output queue (empty/pop): found is set when exactly one colour was seen
// only once and the cursor column is 0 or the last column, and the result
// then carries that cell's column and row (both 0 otherwise). all tables and
// position counters clear after the frame. throughput is one cell per clock
// except where a stall is noted below: the front stage forms the key and
// tracks the position, a four-entry queue decouples it from the back stage,
// which matches the key against all table entries in parallel and updates
// them together. the result reaches the output through the queue entry and
// then the result register, once the queue holds no older cell. only a last
// cell stalls, and only while the previous result still sits unread in the
// one-entry output register. screen_columns is written through the cfg
// channel (always ready) and must only change between frames with the block
// drained; a value of 0 means 256 columns.
`include "unique_background_color_finder_macros.svh"

module unique_background_color_finder import ubcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_screen_columns,
    // cell input
    input  logic             push,
    output logic             full,
    input  logic             i_uses_rgb,
    input  logic [RGB_W-1:0] i_rgb_background,
    input  logic [7:0]       i_vga_attributes,
    input  logic [7:0]       i_hw_cursor_col,
    input  logic             i_last_cell,
    // result output
    output logic             empty,
    input  logic             pop,
    output logic             o_found,
    output logic [7:0]       o_cursor_col,
    output logic [7:0]       o_cursor_row
);

    t_cell     front_cell;
    t_cell     back_cell;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;
    logic      result_pos_zero;

    // a cell beat is taken whenever the middle queue has room
    assign full   = q_status.full;
    assign q_push = push && !q_status.full;

    // key formation, position tracking and the cursor edge test
    ubcf_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_screen_columns (i_cfg_screen_columns),
        .i_accept             (q_push),
        .i_uses_rgb           (i_uses_rgb),
        .i_rgb_background     (i_rgb_background),
        .i_vga_attributes     (i_vga_attributes),
        .i_hw_cursor_col      (i_hw_cursor_col),
        .i_last_cell          (i_last_cell),
        .o_cell               (front_cell)
    );

    // decoupling queue between classification and table update
    ubcf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cell   (front_cell),
        .i_pop    (q_pop),
        .o_cell   (back_cell),
        .o_status (q_status)
    );

    // colour tables, end-of-frame decision and result register
    ubcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell       (back_cell),
        .i_q_status   (q_status),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_found      (o_found),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

    assign result_pos_zero = (o_cursor_col == 8'd0) && (o_cursor_row == 8'd0);

    // the back stage never drains an empty queue
    `UBCF_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_status.empty, "queue underflow")
    // a drain without a fill always frees a slot
    `UBCF_ASSERT_NEXT(a_pop_frees, i_clk, i_rst_n, q_pop && !q_push, !q_status.full, "queue stuck full")
    // a result without a hit carries no position
    `UBCF_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, !empty && !o_found, result_pos_zero, "position on miss")

endmodule

// ===== test/tb_unique_background_color_finder.sv =====
`timescale 1ns / 1ps

module tb_unique_background_color_finder;
    import ubcf_pkg::*;

    // run length and safety net
    localparam int ITEM_TARGET  = 1550;
    localparam int CYCLE_LIMIT  = 200000;
    // a last cell reaches the output through the queue entry and then the result register
    localparam int QUIET_CYCLES = 4;

    // one result beat
    typedef struct packed {
        logic       found;
        logic [7:0] col;
        logic [7:0] row;
    } t_verdict;

    // one cell beat plus an optional hand-typed verdict for the opening rows
    typedef struct packed {
        logic             uses_rgb;
        logic [RGB_W-1:0] rgb;
        logic [7:0]       vga;
        logic [7:0]       hw_col;
        logic             last;
        logic             pinned;
        t_verdict         pin;
    } t_stim_cell;

    typedef enum int {
        SHAPE_PAIRED,
        SHAPE_ONCE_FULL,
        SHAPE_REPEAT_FULL,
        SHAPE_NOISE,
        SHAPE_LONG
    } t_frame_shape;

    localparam t_verdict MISS  = '{1'b0, 8'd0, 8'd0};
    localparam t_verdict HIT00 = '{1'b1, 8'd0, 8'd0};

    // opening rows, all at the reset width of 80 columns (edge column 79)
    t_stim_cell opening_cells [18] = '{
        // lone rgb white cell, cursor at column 0: found at the origin
        '{1'b1, 24'hFFFFFF, 8'h00, 8'd0,   1'b1, 1'b1, HIT00},
        // lone vga black cell, cursor at the edge column
        '{1'b0, 24'h000000, 8'h00, 8'd79,  1'b1, 1'b1, HIT00},
        // lone cell but cursor mid-row: not found
        '{1'b0, 24'hFFFFFF, 8'h70, 8'd5,   1'b1, 1'b1, MISS},
        // cursor past the edge
        '{1'b0, 24'h000000, 8'h70, 8'd255, 1'b1, 1'b1, MISS},
        // vga zero and rgb zero differ by mode: two singles
        '{1'b0, 24'h000000, 8'h8F, 8'd0,   1'b0, 1'b0, MISS},
        '{1'b1, 24'h000000, 8'h00, 8'd0,   1'b1, 1'b1, MISS},
        // vga bits outside 4..6 ignored, rgb pair repeats, one unique left
        '{1'b0, 24'hFFFFFF, 8'h0F, 8'd200, 1'b0, 1'b0, MISS},
        '{1'b0, 24'h123456, 8'h80, 8'd0,   1'b0, 1'b0, MISS},
        '{1'b0, 24'h000000, 8'hFF, 8'd79,  1'b0, 1'b0, MISS},
        '{1'b1, 24'h123456, 8'h00, 8'd0,   1'b0, 1'b0, MISS},
        '{1'b1, 24'h123456, 8'h70, 8'd79,  1'b1, 1'b0, MISS},
        // third sighting of a colour already in the repeat list
        '{1'b1, 24'h00FF00, 8'h55, 8'd0,   1'b0, 1'b0, MISS},
        '{1'b1, 24'h00FF00, 8'hAA, 8'd0,   1'b0, 1'b0, MISS},
        '{1'b1, 24'h00FF00, 8'h00, 8'd0,   1'b0, 1'b0, MISS},
        '{1'b1, 24'hFF0000, 8'h00, 8'd0,   1'b1, 1'b0, MISS},
        // rgb zero and vga key 0x70: two singles
        '{1'b1, 24'h000000, 8'hFF, 8'd255, 1'b0, 1'b0, MISS},
        '{1'b0, 24'h000000, 8'h7F, 8'd0,   1'b1, 1'b1, MISS},
        // all fields at their top value, cursor 255 is no edge here
        '{1'b1, 24'hFFFFFF, 8'hFF, 8'd255, 1'b1, 1'b1, MISS}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_screen_columns;
    logic             push;
    logic             full;
    logic             i_uses_rgb;
    logic [RGB_W-1:0] i_rgb_background;
    logic [7:0]       i_vga_attributes;
    logic [7:0]       i_hw_cursor_col;
    logic             i_last_cell;
    logic             empty;
    logic             pop = 1'b0;
    logic             o_found;
    logic [7:0]       o_cursor_col;
    logic [7:0]       o_cursor_row;

    unique_background_color_finder dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_screen_columns (i_cfg_screen_columns),
        .push                 (push),
        .full                 (full),
        .i_uses_rgb           (i_uses_rgb),
        .i_rgb_background     (i_rgb_background),
        .i_vga_attributes     (i_vga_attributes),
        .i_hw_cursor_col      (i_hw_cursor_col),
        .i_last_cell          (i_last_cell),
        .empty                (empty),
        .pop                  (pop),
        .o_found              (o_found),
        .o_cursor_col         (o_cursor_col),
        .o_cursor_row         (o_cursor_row)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // colour tracker: own copy of the block's tables and position
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] once_key  [MAX_COLORS];
    logic [POS_W-1:0] once_col  [MAX_COLORS];
    logic [POS_W-1:0] once_row  [MAX_COLORS];
    int               once_n      = 0;
    logic [KEY_W-1:0] multi_key [MAX_COLORS];
    int               multi_n     = 0;
    logic [POS_W-1:0] pos_col     = '0;
    logic [POS_W-1:0] pos_row     = '0;
    logic [7:0]       columns_reg = COLUMNS_AT_RESET;

    t_verdict   verdict_q [$];   // verdicts still owed by the block
    t_stim_cell cur;             // cell currently on the input pins
    t_stim_cell frame_q [$];     // cells of the frame being sent

    int send_idle;
    int recv_idle;
    int err_count   = 0;
    int cells_in    = 0;
    int cells_sent;
    int frames_done = 0;
    int found_seen  = 0;
    int col_writes  = 0;
    int cycle_count;
    logic [7:0] cur_columns;   // stimulus-side view of the column register

    // absorbs one cell; returns 1 with the frame verdict on a last cell
    function automatic bit judge_cell(input t_stim_cell c, output t_verdict v);
        logic [KEY_W-1:0] key;
        logic [7:0]       edge_col;
        bit               known;
        int               hit;
        key   = c.uses_rgb ? {1'b1, c.rgb} : {1'b0, 16'h0, c.vga & VGA_BG_MASK};
        known = 1'b0;
        hit   = -1;
        v     = MISS;
        for (int j = 0; j < multi_n; j++)
            if (multi_key[j] == key) known = 1'b1;
        if (!known) begin
            for (int j = 0; j < once_n; j++)
                if (hit < 0 && once_key[j] == key) hit = j;
            if (hit >= 0) begin
                // second sighting: promote, or drop when the repeat list is full
                if (multi_n < MAX_COLORS) begin
                    multi_key[multi_n] = key;
                    multi_n++;
                end
                for (int k = hit; k < once_n - 1; k++) begin
                    once_key[k] = once_key[k + 1];
                    once_col[k] = once_col[k + 1];
                    once_row[k] = once_row[k + 1];
                end
                once_n--;
            end else if (once_n < MAX_COLORS) begin
                once_key[once_n] = key;
                once_col[once_n] = pos_col;
                once_row[once_n] = pos_row;
                once_n++;
            end
        end
        // a column value of 0 wraps to an edge of 255
        edge_col = columns_reg - 8'd1;
        if (!c.last) begin
            if (pos_col == edge_col) begin
                pos_col = '0;
                pos_row = pos_row + 8'd1;
            end else begin
                pos_col = pos_col + 8'd1;
            end
            return 1'b0;
        end
        if ((c.hw_col == 8'd0 || c.hw_col == edge_col) && once_n == 1)
            v = '{1'b1, once_col[0], once_row[0]};
        once_n  = 0;
        multi_n = 0;
        pos_col = '0;
        pos_row = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // monitor: config beats, cell beats and result beats, all at posedge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_verdict v;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                columns_reg = i_cfg_screen_columns;
                col_writes++;
            end
            if (push && !full) begin
                cells_in++;
                if (judge_cell(cur, v)) begin
                    // hand-typed verdicts replace the prediction
                    if (cur.pinned) v = cur.pin;
                    verdict_q.push_back(v);
                end
            end
            if (pop && !empty) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch("result beat with no frame pending");
                end else begin
                    v = verdict_q.pop_front();
                    if (o_found !== v.found)
                        flag_mismatch($sformatf("frame %0d found: got %b want %b",
                                                frames_done, o_found, v.found));
                    if (o_cursor_col !== v.col)
                        flag_mismatch($sformatf("frame %0d col: got %0d want %0d",
                                                frames_done, o_cursor_col, v.col));
                    if (o_cursor_row !== v.row)
                        flag_mismatch($sformatf("frame %0d row: got %0d want %0d",
                                                frames_done, o_cursor_row, v.row));
                    if (v.found) found_seen++;
                end
                frames_done++;
            end
        end
    end

    // result side: random back-pressure at the configured rate
    always @(negedge i_clk) begin
        if (i_rst_n) pop <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d frames still pending",
                 cycle_count, verdict_q.size());
        $display("unique_background_color_finder verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // random colour key, biased toward vga keys and rgb extremes
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(7))
            0, 1:    return {1'b0, 16'h0, 8'($urandom) & VGA_BG_MASK};
            2:       return {1'b1, 24'hFFFFFF};
            3:       return {1'b1, 24'h000000};
            default: return {1'b1, 24'($urandom)};
        endcase
    endfunction

    // n distinct keys
    function automatic void pick_palette(ref logic [KEY_W-1:0] pal [$], input int n);
        logic [KEY_W-1:0] k;
        bit               dup;
        pal.delete();
        while (pal.size() < n) begin
            k   = rand_key();
            dup = 1'b0;
            foreach (pal[i]) if (pal[i] == k) dup = 1'b1;
            if (!dup) pal.push_back(k);
        end
    endfunction

    // turn a key into pin values; unused colour bits get random filler
    function automatic t_stim_cell make_cell(input logic [KEY_W-1:0] key, input bit last,
                                             input logic [7:0] hw);
        t_stim_cell c;
        c.uses_rgb = key[KEY_W-1];
        c.rgb      = key[KEY_W-1] ? key[RGB_W-1:0] : 24'($urandom);
        c.vga      = key[KEY_W-1] ? 8'($urandom)
                                  : ((8'($urandom) & ~VGA_BG_MASK) | key[7:0]);
        c.hw_col   = last ? hw : 8'($urandom);
        c.last     = last;
        c.pinned   = 1'b0;
        c.pin      = MISS;
        return c;
    endfunction

    // fill frame_q with one frame of the given shape
    task automatic build_frame(input t_frame_shape shape, input int long_len);
        logic [KEY_W-1:0] pal [$];
        logic [KEY_W-1:0] seq [$];
        logic [KEY_W-1:0] tmp;
        logic [7:0]       cursor;
        int               n;
        int               uniq;
        int               j;
        frame_q.delete();
        case (shape)
            SHAPE_PAIRED: begin
                // repeated colours plus usually exactly one lone colour
                n    = $urandom_range(1, 6);
                uniq = ($urandom_range(9) < 7) ? 1 : 2 * $urandom_range(1);
                pick_palette(pal, n + uniq);
                for (int i = 0; i < n; i++)
                    repeat ($urandom_range(2, 3)) seq.push_back(pal[i]);
                for (int i = n; i < n + uniq; i++) seq.push_back(pal[i]);
                for (int i = seq.size() - 1; i > 0; i--) begin
                    j      = $urandom_range(i);
                    tmp    = seq[i];
                    seq[i] = seq[j];
                    seq[j] = tmp;
                end
            end
            SHAPE_ONCE_FULL: begin
                // overfill the single list, then free slots with repeats
                n = $urandom_range(17, 20);
                pick_palette(pal, n);
                foreach (pal[i]) seq.push_back(pal[i]);
                for (int i = 0; i < MAX_COLORS; i++)
                    if ($urandom_range(3) != 0) seq.push_back(pal[i]);
                if ($urandom_range(1)) seq.push_back(pal[n - 1]);
            end
            SHAPE_REPEAT_FULL: begin
                // overfill the repeat list; dropped colours come back as new
                n = $urandom_range(17, 19);
                pick_palette(pal, n);
                foreach (pal[i]) begin
                    seq.push_back(pal[i]);
                    seq.push_back(pal[i]);
                end
                for (int i = MAX_COLORS; i < n; i++) seq.push_back(pal[i]);
                if ($urandom_range(1)) seq.push_back(pal[0]);
            end
            SHAPE_NOISE: begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    if (i > 0 && $urandom_range(3) == 0)
                        seq.push_back(seq[$urandom_range(i - 1)]);
                    else
                        seq.push_back(rand_key());
            end
            SHAPE_LONG: begin
                // long frame, lone colour placed past cell 255 to wrap the position
                pick_palette(pal, 4);
                for (int i = 0; i < long_len - 1; i++)
                    seq.push_back(pal[(i < 6) ? (i % 3) : $urandom_range(2)]);
                seq.insert($urandom_range(256, long_len - 1), pal[3]);
            end
            default: ;
        endcase
        // cursor mostly on an edge column so that found can come up
        case ($urandom_range(9))
            0, 1, 2, 3: cursor = 8'd0;
            4, 5, 6, 7: cursor = cur_columns - 8'd1;
            default:    cursor = 8'($urandom);
        endcase
        foreach (seq[i])
            frame_q.push_back(make_cell(seq[i], i == seq.size() - 1, cursor));
    endtask

    // one cell beat, with random gaps before it
    task automatic send_cell(input t_stim_cell c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push             <= 1'b1;
        cur              <= c;
        i_uses_rgb       <= c.uses_rgb;
        i_rgb_background <= c.rgb;
        i_vga_attributes <= c.vga;
        i_hw_cursor_col  <= c.hw_col;
        i_last_cell      <= c.last;
        do @(posedge i_clk); while (full);
        cells_sent++;
    endtask

    // hold off the input until every owed verdict has come out
    task automatic settle_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // column register beat, only with the block drained
    task automatic write_columns(input logic [7:0] val);
        settle_idle();
        i_cfg_valid          <= 1'b1;
        i_cfg_screen_columns <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_columns = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]   column_plan [5] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd80};
        logic [7:0]   cols;
        t_frame_shape shape;
        int           phase;
        int           nframes;

        // everything known from time zero
        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_screen_columns = '0;
        push                 = 1'b0;
        i_uses_rgb           = 1'b0;
        i_rgb_background     = '0;
        i_vga_attributes     = '0;
        i_hw_cursor_col      = '0;
        i_last_cell          = 1'b0;
        cur                  = '0;
        cur_columns          = COLUMNS_AT_RESET;
        cells_sent           = 0;
        send_idle            = 29;
        recv_idle            = 29;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // opening rows at the reset column count
        foreach (opening_cells[i]) send_cell(opening_cells[i]);

        // random phases, each with its own column count
        phase = 0;
        while (cells_sent < ITEM_TARGET) begin
            cols = (phase < 5) ? column_plan[phase] : 8'($urandom);
            // one phase runs with no gaps on either side
            send_idle = (phase == 2) ? 0 : 29;
            recv_idle = send_idle;
            write_columns(cols);
            // row wrap at one column, column wrap at 256 columns
            if (phase < 5 && (cols == 8'd1 || cols == 8'd0)) begin
                build_frame(SHAPE_LONG, $urandom_range(257, 300));
                foreach (frame_q[i]) send_cell(frame_q[i]);
            end
            nframes = $urandom_range(6, 12);
            for (int f = 0; f < nframes && cells_sent < ITEM_TARGET; f++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: shape = SHAPE_PAIRED;
                    6:                shape = SHAPE_ONCE_FULL;
                    7:                shape = SHAPE_REPEAT_FULL;
                    default:          shape = SHAPE_NOISE;
                endcase
                build_frame(shape, 0);
                foreach (frame_q[i]) send_cell(frame_q[i]);
                // now and then let the result side run dry mid-phase
                if ($urandom_range(7) == 0) settle_idle();
            end
            phase++;
        end

        settle_idle();
        $display("run covered %0d cells in %0d frames over %0d column settings",
                 cells_in, frames_done, col_writes);
        $display("%0d frames reported a unique colour, %0d mismatches",
                 found_seen, err_count);
        if (err_count == 0)
            $display("unique_background_color_finder verification clean");
        else
            $display("unique_background_color_finder verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ubcf_pkg.sv
rtl/core/ubcf_front.sv
rtl/core/ubcf_queue.sv
rtl/core/ubcf_back.sv
rtl/core/unique_background_color_finder.sv
test/tb_unique_background_color_finder.sv
